/* rtl/sktbl_pkg.sv */
// Shared types, codes and default sizes for the sorted key/value table.
// Used by the controller, the datapath, the top level and the port checker.
package sktbl_pkg;

    // Default sizes of the table.
    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Request operation codes.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Memory read address selection.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } t_rd_sel;

    // Memory write selection.
    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_NEW,
        WR_VALUE
    } t_wr_mode;

    // Walking index update.
    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC,
        IDX_CNT
    } t_idx_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_req;
        t_rd_sel    rd_sel;
        t_wr_mode   wr_mode;
        t_idx_op    idx_op;
        logic       pos_save;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_take_rd;
        logic       out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       idx_at_count;
        logic       key_lt;
        logic       key_eq;
        logic       full;
        logic       idx_m1_at_pos;
        logic       idx_p1_lt_count;
    } t_dp_sts;

endpackage

/* rtl/sorted_key_value_table.sv */
// Sorted key/value table: holds up to DEPTH entries in ascending key order.
// Channels: request (i_in_valid/o_in_ready with i_op, i_key, i_entry_value)
// and result (o_out_valid/i_out_ready with o_status, o_read_value,
// o_is_empty). Every request yields exactly one result transaction.
// Operations: put inserts a key not yet present at the sorted place, get returns and removes,
// read returns, write replaces the value of an existing key.
// A request is processed one at a time. The keys and values live in
// memories with a single registered read port, so the lookup walks the
// table entry by entry, with a read state and a compare state per entry,
// up to the key's sorted place, and put and get then move each following
// entry with a read and a write. The block takes its next request in the
// cycle after the previous result is loaded into the output register.
// A finished result waits in the output register while the receiver
// stalls; the block keeps accepting a request meanwhile and holds its next
// result until the output register is free.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending
// result; the memories need no clearing.
// Depends on sktbl_pkg, sktbl_ctrl and sktbl_datapath.
module sorted_key_value_table #(
    parameter int DEPTH      = sktbl_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = sktbl_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = sktbl_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_op,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_entry_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic                  o_is_empty
);

    sktbl_pkg::t_dp_cmd cmd;
    sktbl_pkg::t_dp_sts sts;

    // Control sequencer.
    sktbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Storage and result path.
    sktbl_datapath #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_entry_value (i_entry_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_is_empty    (o_is_empty)
    );

endmodule

/* rtl/sktbl_datapath.sv */
// Datapath of the sorted key/value table: request registers, key and value
// memories, index and count registers, result and output registers. Uses sktbl_pkg.
module sktbl_datapath #(
    parameter int DEPTH      = sktbl_pkg::DEPTH_DEF,
    parameter int KEY_BITS   = sktbl_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = sktbl_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_op,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_entry_value,
    input  sktbl_pkg::t_dp_cmd    i_cmd,
    output sktbl_pkg::t_dp_sts    o_sts,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic                  o_is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Key and value memories, one read and one write port each.
    logic [KEY_BITS-1:0]   r_keys [DEPTH];
    logic [VALUE_BITS-1:0] r_vals [DEPTH];

    logic [1:0]            r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_pos;
    logic [CW-1:0]         r_count;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [1:0]            r_res_status;
    logic [VALUE_BITS-1:0] r_res_rd;
    logic [1:0]            r_out_status;
    logic [VALUE_BITS-1:0] r_out_rd;
    logic                  r_out_empty;

    logic [CW-1:0] n_idx;
    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_p1;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign idx_m1  = r_idx - CW'(1);
    assign idx_p1  = r_idx + CW'(1);
    assign wr_addr = r_idx[AW-1:0];

    // Read address selection.
    always_comb begin
        unique case (i_cmd.rd_sel)
            sktbl_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            sktbl_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
            default:              rd_addr = r_idx[AW-1:0];
        endcase
    end

    // Registered memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sel != sktbl_pkg::RD_NONE) begin
            r_rd_key <= r_keys[rd_addr];
            r_rd_val <= r_vals[rd_addr];
        end
    end

    // Memory write: shifted entry, new entry, or value update.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.wr_mode)
            sktbl_pkg::WR_SHIFT: begin
                r_keys[wr_addr] <= r_rd_key;
                r_vals[wr_addr] <= r_rd_val;
            end
            sktbl_pkg::WR_NEW: begin
                r_keys[wr_addr] <= r_key;
                r_vals[wr_addr] <= r_val;
            end
            sktbl_pkg::WR_VALUE: begin
                r_vals[wr_addr] <= r_val;
            end
            default: begin
            end
        endcase
    end

    // Next walking index.
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.load_req) begin
            n_idx = '0;
        end else begin
            unique case (i_cmd.idx_op)
                sktbl_pkg::IDX_INC: n_idx = idx_p1;
                sktbl_pkg::IDX_DEC: n_idx = idx_m1;
                sktbl_pkg::IDX_CNT: n_idx = r_count;
                default:            n_idx = r_idx;
            endcase
        end
    end

    // Index and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Request capture, insert position and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_val <= i_entry_value;
        end
        if (i_cmd.pos_save) begin
            r_pos <= r_idx;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_rd     <= i_cmd.res_take_rd ? r_rd_val : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_rd     <= r_res_rd;
            r_out_empty  <= (r_count == '0);
        end
    end

    // Status toward the controller.
    assign o_sts.op              = r_op;
    assign o_sts.idx_at_count    = (r_idx == r_count);
    assign o_sts.key_lt          = (r_rd_key < r_key);
    assign o_sts.key_eq          = (r_rd_key == r_key);
    assign o_sts.full            = (r_count == CW'(DEPTH));
    assign o_sts.idx_m1_at_pos   = (idx_m1 == r_pos);
    assign o_sts.idx_p1_lt_count = (idx_p1 < r_count);

    assign o_status     = r_out_status;
    assign o_read_value = r_out_rd;
    assign o_is_empty   = r_out_empty;

endmodule

/* rtl/sktbl_ctrl.sv */
// Controller of the sorted key/value table: sequences the scan, the shift
// sweeps and the result handoff. Uses sktbl_pkg command and status types.
module sktbl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  sktbl_pkg::t_dp_sts i_sts,
    output sktbl_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_SHR      = 4'd3;
    localparam logic [3:0] S_SHW      = 4'd4;
    localparam logic [3:0] S_INS      = 4'd5;
    localparam logic [3:0] S_SDN      = 4'd6;
    localparam logic [3:0] S_SDW      = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       finish;
    logic       hit;

    // State sequencing and command generation.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        finish  = 1'b0;
        hit     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.idx_at_count) begin
                    finish = 1'b1;
                end else begin
                    o_cmd.rd_sel = sktbl_pkg::RD_IDX;
                    n_state      = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.key_lt) begin
                    o_cmd.idx_op = sktbl_pkg::IDX_INC;
                    n_state      = S_SCAN_RD;
                end else begin
                    finish = 1'b1;
                    hit    = i_sts.key_eq;
                end
            end
            S_SHR: begin
                o_cmd.rd_sel = sktbl_pkg::RD_IDX_M1;
                n_state      = S_SHW;
            end
            S_SHW: begin
                o_cmd.wr_mode = sktbl_pkg::WR_SHIFT;
                o_cmd.idx_op  = sktbl_pkg::IDX_DEC;
                n_state       = i_sts.idx_m1_at_pos ? S_INS : S_SHR;
            end
            S_INS: begin
                o_cmd.wr_mode    = sktbl_pkg::WR_NEW;
                o_cmd.cnt_inc    = 1'b1;
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = sktbl_pkg::ST_OK;
                n_state          = S_DONE;
            end
            S_SDN: begin
                if (i_sts.idx_p1_lt_count) begin
                    o_cmd.rd_sel = sktbl_pkg::RD_IDX_P1;
                    n_state      = S_SDW;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_SDW: begin
                o_cmd.wr_mode = sktbl_pkg::WR_SHIFT;
                o_cmd.idx_op  = sktbl_pkg::IDX_INC;
                n_state       = S_SDN;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The scan has found the lower bound; act on the operation.
        if (finish) begin
            o_cmd.res_set    = 1'b1;
            o_cmd.res_status = sktbl_pkg::ST_MISS;
            n_state          = S_DONE;
            case (i_sts.op)
                sktbl_pkg::OP_PUT: begin
                    if (hit) begin
                        o_cmd.res_set = 1'b1;
                    end else if (i_sts.full) begin
                        o_cmd.res_status = sktbl_pkg::ST_FULL;
                    end else begin
                        o_cmd.res_set  = 1'b0;
                        o_cmd.pos_save = 1'b1;
                        o_cmd.idx_op   = sktbl_pkg::IDX_CNT;
                        n_state        = i_sts.idx_at_count ? S_INS : S_SHR;
                    end
                end
                sktbl_pkg::OP_GET: begin
                    if (hit) begin
                        o_cmd.res_status  = sktbl_pkg::ST_OK;
                        o_cmd.res_take_rd = 1'b1;
                        n_state           = S_SDN;
                    end
                end
                sktbl_pkg::OP_READ: begin
                    if (hit) begin
                        o_cmd.res_status  = sktbl_pkg::ST_OK;
                        o_cmd.res_take_rd = 1'b1;
                    end
                end
                default: begin
                    if (hit) begin
                        o_cmd.wr_mode    = sktbl_pkg::WR_VALUE;
                        o_cmd.res_status = sktbl_pkg::ST_OK;
                    end
                end
            endcase
        end
    end

    // Output valid: set on load, cleared when the result is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/sktbl_chk.sv */
// Port-level checker for the sorted key/value table, bound to the top level.
// Uses sktbl_pkg status codes.
module sktbl_chk #(
    parameter int KEY_BITS   = sktbl_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = sktbl_pkg::VALUE_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [1:0]            i_op,
    input logic [KEY_BITS-1:0]   i_key,
    input logic [VALUE_BITS-1:0] i_entry_value,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [1:0]            o_status,
    input logic [VALUE_BITS-1:0] o_read_value,
    input logic                  o_is_empty
);

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == sktbl_pkg::ST_OK || o_status == sktbl_pkg::ST_MISS
                         || o_status == sktbl_pkg::ST_FULL))
        else $error("undefined status code");

    // A failed request returns a zero value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != sktbl_pkg::ST_OK |-> o_read_value == '0)
        else $error("nonzero value on failed request");

    // A waiting request holds its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_op)
                                      && $stable(i_key) && $stable(i_entry_value))
        else $error("waiting request changed");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
                                        && $stable(o_read_value) && $stable(o_is_empty))
        else $error("stalled result changed");

endmodule

bind sorted_key_value_table sktbl_chk #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_sktbl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_op          (i_op),
    .i_key         (i_key),
    .i_entry_value (i_entry_value),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_read_value  (o_read_value),
    .o_is_empty    (o_is_empty)
);
